// File: hw/rtl/aled_pkg.sv
// Shared constants, types and the channel scaling function for the LED frame encoder.
// No dependencies; the top level refers to it by scoped names.
package aled_pkg;

	localparam int LEDS_PER_STRIP   = 64;
	localparam int RESET_SLOT_COUNT = 50;
	localparam int BITS_PER_PIXEL   = 24;

	localparam int IDX_W = (LEDS_PER_STRIP > 1) ? $clog2(LEDS_PER_STRIP) : 1;
	localparam int CNT_W = $clog2(LEDS_PER_STRIP + 1);
	localparam int RST_W = $clog2(RESET_SLOT_COUNT);
	localparam int BIT_W = $clog2(BITS_PER_PIXEL);

	typedef enum logic [1:0] {
		CMD_SET  = 2'd0,
		CMD_FILL = 2'd1,
		CMD_SHOW = 2'd2,
		CMD_TICK = 2'd3
	} cmd_t;

	localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
	localparam logic [1:0] CFG_DUTY_ONE   = 2'd1;
	localparam logic [1:0] CFG_DUTY_ZERO  = 2'd2;

	localparam logic [7:0]  BRIGHTNESS_RST = 8'd255;
	localparam logic [15:0] DUTY_ONE_RST   = 16'd67;
	localparam logic [15:0] DUTY_ZERO_RST  = 16'd34;

	typedef struct packed {
		logic        accepted;
		logic        busy;
		logic [15:0] duty0;
		logic [15:0] duty1;
		logic        done;
	} res_t;

	function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [7:0] b);
		logic [16:0] prod;
		prod = 17'(c) * (17'(b) + 17'd1);
		return prod[15:8];
	endfunction

	// pixel is {red, green, blue}; encoded word is {green, red, blue}
	function automatic logic [23:0] encode_grb(input logic [23:0] p, input logic [7:0] b);
		return {scale_ch(p[15:8], b), scale_ch(p[23:16], b), scale_ch(p[7:0], b)};
	endfunction

endpackage

// File: hw/rtl/addressable_led_frame_encoder_unit.sv
// Two-strip addressable LED frame encoder: pixel store, show sweep and bit-slot emission.
// Depends on aled_pkg.
//
// channel  | direction | handshake          | payload
// s_       | in        | s_tvalid/s_tready  | s_tuser command, s_tdata pixel fields
// m_       | out       | m_tvalid/m_tready  | m_tdata duties and flags, m_tlast frame end
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Fill writes its clipped range through the single write port of the pixel memory; show sweeps
// every entry through a registered memory read, and a tick takes its word from a registered read.
// Reset clears the pixel store at once through per-entry valid bits; no clearing pass.
// Input is taken only when idle; a result waits in the output register for m_tready.
module addressable_led_frame_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // command
	input  logic [47:0] s_tdata,  // strip, first_index, count, red, green, blue, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // accepted, busy_res, duty_strip_zero, duty_strip_one, pad
	output logic        m_tlast,  // frame_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int N     = aled_pkg::LEDS_PER_STRIP;
	localparam int IDX_W = aled_pkg::IDX_W;
	localparam int CNT_W = aled_pkg::CNT_W;
	localparam int RST_W = aled_pkg::RST_W;
	localparam int BIT_W = aled_pkg::BIT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_SHOW,
		ST_TICK,
		ST_RESULT
	} state_t;

	state_t state_q;

	logic [7:0]  brightness_q;
	logic [15:0] duty_one_q;
	logic [15:0] duty_zero_q;

	logic                in_flight_q;
	logic                phase_rst_q;
	logic [IDX_W-1:0]    pix_q;
	logic [BIT_W-1:0]    bit_q;
	logic [RST_W-1:0]    rst_q;

	logic [CNT_W-1:0]    fill_idx_q;
	logic [CNT_W-1:0]    fill_end_q;
	logic                fill_strip_q;
	logic [23:0]         fill_colour_q;
	logic [CNT_W-1:0]    sweep_q;

	logic [1:0]          valid_q [N];
	aled_pkg::res_t      res_q;
	logic                m_tvalid_q;
	logic [39:0]         m_tdata_q;
	logic                m_tlast_q;

	logic [1:0][23:0]    pix_mem [N];
	logic [47:0]         enc_mem [N];
	logic [1:0][23:0]    pix_rd_s1;
	logic [1:0]          vld_rd_s1;
	logic                rd_valid_s1;
	logic [IDX_W-1:0]    addr_s1;
	logic [47:0]         enc_rd_s1;

	aled_pkg::cmd_t      cmd_in;
	logic                strip_in;
	logic [9:0]          first_in;
	logic [10:0]         count_in;
	logic [23:0]         colour_in;
	logic                accept;
	logic                first_ok;
	logic [11:0]         fill_sum;
	logic [CNT_W-1:0]    fill_end;
	logic                frame_end;

	logic                pix_we;
	logic [IDX_W-1:0]    pix_waddr;
	logic                pix_wstrip;
	logic [23:0]         pix_wdata;
	logic                pix_re;
	logic                enc_re;
	logic [23:0]         enc0;
	logic [23:0]         enc1;

	assign cmd_in    = aled_pkg::cmd_t'(s_tuser);
	assign strip_in  = s_tdata[0];
	assign first_in  = s_tdata[10:1];
	assign count_in  = s_tdata[21:11];
	assign colour_in = {s_tdata[29:22], s_tdata[37:30], s_tdata[45:38]};

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign first_ok = {1'b0, first_in} < 11'(N);
	assign fill_sum = 12'(first_in) + 12'(count_in);
	assign fill_end = (fill_sum > 12'(N)) ? CNT_W'(N) : fill_sum[CNT_W-1:0];

	assign frame_end = cmd_in == aled_pkg::CMD_TICK && in_flight_q && phase_rst_q &&
	                   rst_q == RST_W'(aled_pkg::RESET_SLOT_COUNT - 1);

	assign pix_we     = (accept && cmd_in == aled_pkg::CMD_SET && first_ok) ||
	                    (state_q == ST_FILL);
	assign pix_waddr  = (state_q == ST_FILL) ? fill_idx_q[IDX_W-1:0] : first_in[IDX_W-1:0];
	assign pix_wstrip = (state_q == ST_FILL) ? fill_strip_q : strip_in;
	assign pix_wdata  = (state_q == ST_FILL) ? fill_colour_q : colour_in;

	assign pix_re = (state_q == ST_SHOW) && (sweep_q < CNT_W'(N));
	assign enc_re = accept && cmd_in == aled_pkg::CMD_TICK && in_flight_q && !phase_rst_q;

	assign enc0 = aled_pkg::encode_grb(vld_rd_s1[0] ? pix_rd_s1[0] : 24'd0, brightness_q);
	assign enc1 = aled_pkg::encode_grb(vld_rd_s1[1] ? pix_rd_s1[1] : 24'd0, brightness_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[pix_waddr][pix_wstrip] <= pix_wdata;
		end
		if (pix_re) begin
			pix_rd_s1 <= pix_mem[sweep_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			enc_mem[addr_s1] <= {enc1, enc0};
		end
		if (enc_re) begin
			enc_rd_s1 <= enc_mem[pix_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			brightness_q  <= aled_pkg::BRIGHTNESS_RST;
			duty_one_q    <= aled_pkg::DUTY_ONE_RST;
			duty_zero_q   <= aled_pkg::DUTY_ZERO_RST;
			in_flight_q   <= 1'b0;
			phase_rst_q   <= 1'b0;
			pix_q         <= '0;
			bit_q         <= BIT_W'(aled_pkg::BITS_PER_PIXEL - 1);
			rst_q         <= '0;
			fill_idx_q    <= '0;
			fill_end_q    <= '0;
			fill_strip_q  <= 1'b0;
			fill_colour_q <= '0;
			sweep_q       <= '0;
			for (int i = 0; i < N; i++) begin
				valid_q[i] <= 2'b00;
			end
			vld_rd_s1     <= 2'b00;
			rd_valid_s1   <= 1'b0;
			addr_s1       <= '0;
			res_q         <= '0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
			m_tlast_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					aled_pkg::CFG_BRIGHTNESS: brightness_q <= cfg_data[7:0];
					aled_pkg::CFG_DUTY_ONE:   duty_one_q   <= cfg_data;
					aled_pkg::CFG_DUTY_ZERO:  duty_zero_q  <= cfg_data;
					default: ;
				endcase
			end

			if (pix_we) begin
				valid_q[pix_waddr][pix_wstrip] <= 1'b1;
			end

			rd_valid_s1 <= pix_re;
			if (pix_re) begin
				addr_s1   <= sweep_q[IDX_W-1:0];
				vld_rd_s1 <= valid_q[sweep_q[IDX_W-1:0]];
			end

			if (m_tready && state_q != ST_RESULT) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q <= '{accepted: !(cmd_in == aled_pkg::CMD_SHOW && in_flight_q),
						           busy: in_flight_q && !frame_end,
						           duty0: 16'd0, duty1: 16'd0, done: frame_end};
						unique case (cmd_in)
							aled_pkg::CMD_SET: state_q <= ST_RESULT;
							aled_pkg::CMD_FILL: begin
								if (first_ok && count_in != 11'd0) begin
									fill_idx_q    <= CNT_W'(first_in[IDX_W-1:0]);
									fill_end_q    <= fill_end;
									fill_strip_q  <= strip_in;
									fill_colour_q <= colour_in;
									state_q       <= ST_FILL;
								end else begin
									state_q <= ST_RESULT;
								end
							end
							aled_pkg::CMD_SHOW: begin
								if (in_flight_q) begin
									state_q <= ST_RESULT;
								end else begin
									sweep_q <= '0;
									state_q <= ST_SHOW;
								end
							end
							aled_pkg::CMD_TICK: begin
								if (in_flight_q && !phase_rst_q) begin
									state_q <= ST_TICK;
								end else begin
									state_q <= ST_RESULT;
									if (frame_end) begin
										in_flight_q <= 1'b0;
										phase_rst_q <= 1'b0;
										rst_q       <= '0;
									end else if (in_flight_q) begin
										rst_q <= rst_q + RST_W'(1);
									end
								end
							end
							default: state_q <= ST_RESULT;
						endcase
					end
				end
				ST_FILL: begin
					fill_idx_q <= fill_idx_q + CNT_W'(1);
					if (fill_idx_q + CNT_W'(1) == fill_end_q) begin
						state_q <= ST_RESULT;
					end
				end
				ST_SHOW: begin
					sweep_q <= sweep_q + CNT_W'(1);
					if (sweep_q == CNT_W'(N)) begin
						in_flight_q <= 1'b1;
						phase_rst_q <= 1'b0;
						pix_q       <= '0;
						bit_q       <= BIT_W'(aled_pkg::BITS_PER_PIXEL - 1);
						rst_q       <= '0;
						res_q.busy  <= 1'b1;
						state_q     <= ST_RESULT;
					end
				end
				ST_TICK: begin
					res_q.duty0 <= enc_rd_s1[{1'b0, bit_q}] ? duty_one_q : duty_zero_q;
					res_q.duty1 <= enc_rd_s1[6'(bit_q) + 6'd24] ? duty_one_q : duty_zero_q;
					if (bit_q == '0) begin
						bit_q <= BIT_W'(aled_pkg::BITS_PER_PIXEL - 1);
						if (pix_q == IDX_W'(N - 1)) begin
							pix_q       <= '0;
							phase_rst_q <= 1'b1;
						end else begin
							pix_q <= pix_q + IDX_W'(1);
						end
					end else begin
						bit_q <= bit_q - BIT_W'(1);
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'd0, res_q.duty1, res_q.duty0, res_q.busy, res_q.accepted};
						m_tlast_q  <= res_q.done;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_frame_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[1])
		else $error("frame end reported with busy set");

	a_sweep_in_show: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(state_q == ST_SHOW))
		else $error("pixel read outside show sweep");

	a_busy_from_show: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_flight_q) |-> $past(state_q == ST_SHOW))
		else $error("frame started without a show");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> fill_idx_q < fill_end_q && fill_end_q <= CNT_W'(N))
		else $error("fill index out of range");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking bench for addressable_led_frame_encoder_unit: pixel, show and tick items,
// checked against an in-bench model of the two-strip frame engine. Needs aled_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_SLOTS  = aled_pkg::LEDS_PER_STRIP * aled_pkg::BITS_PER_PIXEL;
	localparam int TOTAL_SLOTS = DATA_SLOTS + aled_pkg::RESET_SLOT_COUNT;
	localparam int STUCK_LIMIT = 3000;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		aled_pkg::cmd_t cmd;
		bit        strip;
		bit [9:0]  first;
		bit [10:0] count;
		bit [7:0]  red;
		bit [7:0]  green;
		bit [7:0]  blue;
	} led_cmd_t;

	class led_frame_scoreboard;
		bit [23:0]   colors [2][aled_pkg::LEDS_PER_STRIP];
		bit [23:0]   grb_words [2][aled_pkg::LEDS_PER_STRIP];
		int unsigned slot;
		bit          sending;
		bit [7:0]    scale;
		bit [15:0]   duty_hi;
		bit [15:0]   duty_lo;
		aled_pkg::res_t pending_results [$];
		int unsigned mismatches;

		function new();
			scale   = aled_pkg::BRIGHTNESS_RST;
			duty_hi = aled_pkg::DUTY_ONE_RST;
			duty_lo = aled_pkg::DUTY_ZERO_RST;
		endfunction

		function void load_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				aled_pkg::CFG_BRIGHTNESS: scale = val[7:0];
				aled_pkg::CFG_DUTY_ONE: duty_hi = val;
				aled_pkg::CFG_DUTY_ZERO: duty_lo = val;
				default: ;
			endcase
		endfunction

		function bit [7:0] dim(bit [7:0] c);
			int unsigned prod;
			prod = c * (int'(scale) + 1);
			return 8'(prod >> 8);
		endfunction

		function void apply_cmd(led_cmd_t c);
			aled_pkg::res_t r;
			bit   [23:0] p;
			int unsigned pix;
			int unsigned pos;
			r = '0;
			r.accepted = 1'b1;
			case (c.cmd)
				aled_pkg::CMD_SET: begin
					if (c.first < aled_pkg::LEDS_PER_STRIP)
						colors[c.strip][c.first] = {c.red, c.green, c.blue};
				end
				aled_pkg::CMD_FILL: begin
					for (int unsigned i = 0;
					     i < c.count && c.first + i < aled_pkg::LEDS_PER_STRIP; i++)
						colors[c.strip][c.first + i] = {c.red, c.green, c.blue};
				end
				aled_pkg::CMD_SHOW: begin
					if (sending) begin
						r.accepted = 1'b0;
					end else begin
						for (int k = 0; k < 2; k++)
							for (int i = 0; i < aled_pkg::LEDS_PER_STRIP; i++) begin
								p = colors[k][i];
								grb_words[k][i] = {dim(p[15:8]), dim(p[23:16]), dim(p[7:0])};
							end
						slot    = 0;
						sending = 1'b1;
					end
				end
				default: begin
					if (sending) begin
						if (slot < DATA_SLOTS) begin
							pix = slot / aled_pkg::BITS_PER_PIXEL;
							pos = aled_pkg::BITS_PER_PIXEL - 1 - slot % aled_pkg::BITS_PER_PIXEL;
							r.duty0 = grb_words[0][pix][pos] ? duty_hi : duty_lo;
							r.duty1 = grb_words[1][pix][pos] ? duty_hi : duty_lo;
						end
						if (slot + 1 >= TOTAL_SLOTS) begin
							r.done  = 1'b1;
							sending = 1'b0;
							slot    = 0;
						end else begin
							slot++;
						end
					end
				end
			endcase
			r.busy = sending;
			pending_results.push_back(r);
		endfunction

		function void note_mismatch(string what, logic [15:0] want, logic [15:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %h, actual %h", what, want, got);
		endfunction

		function void check_result(aled_pkg::res_t got);
			aled_pkg::res_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with none expected: %h", got);
				return;
			end
			want = pending_results.pop_front();
			if (got.accepted !== want.accepted)
				note_mismatch("accepted", 16'(want.accepted), 16'(got.accepted));
			if (got.busy !== want.busy)
				note_mismatch("busy", 16'(want.busy), 16'(got.busy));
			if (got.duty0 !== want.duty0) note_mismatch("duty strip 0", want.duty0, got.duty0);
			if (got.duty1 !== want.duty1) note_mismatch("duty strip 1", want.duty1, got.duty1);
			if (got.done !== want.done)
				note_mismatch("frame done", 16'(want.done), 16'(got.done));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	led_frame_scoreboard sb = new();
	bit          rush;
	int unsigned hold_off;
	int unsigned stuck_cycles;

	addressable_led_frame_encoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		led_cmd_t seen;
		aled_pkg::res_t got;
		if (arst_n) begin
			stuck_cycles++;
			if (cfg_valid && cfg_ready) begin
				sb.load_reg(cfg_index, cfg_data);
				stuck_cycles = 0;
			end
			if (m_tvalid && m_tready) begin
				got.accepted = m_tdata[0];
				got.busy     = m_tdata[1];
				got.duty0    = m_tdata[17:2];
				got.duty1    = m_tdata[33:18];
				got.done     = m_tlast;
				sb.check_result(got);
				stuck_cycles = 0;
			end
			if (s_tvalid && s_tready) begin
				seen.cmd   = aled_pkg::cmd_t'(s_tuser);
				seen.strip = s_tdata[0];
				seen.first = s_tdata[10:1];
				seen.count = s_tdata[21:11];
				seen.red   = s_tdata[29:22];
				seen.green = s_tdata[37:30];
				seen.blue  = s_tdata[45:38];
				sb.apply_cmd(seen);
				stuck_cycles = 0;
			end
		end
	end

	initial begin
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// result side: random stalls per item, one long hold-off on request
	initial begin
		int unsigned gap;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end
			gap = rush ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic led_cmd_t pixel_cmd(aled_pkg::cmd_t op, bit st, int unsigned first,
			int unsigned cnt, bit [7:0] r, bit [7:0] g, bit [7:0] b);
		led_cmd_t c;
		c.cmd   = op;
		c.strip = st;
		c.first = 10'(first);
		c.count = 11'(cnt);
		c.red   = r;
		c.green = g;
		c.blue  = b;
		return c;
	endfunction

	function automatic led_cmd_t random_pixel_cmd();
		led_cmd_t    c;
		int unsigned pick;
		c.strip = 1'($urandom_range(0, 1));
		c.first = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
			: 10'($urandom_range(0, aled_pkg::LEDS_PER_STRIP - 1));
		case ($urandom_range(0, 4))
			0: c.count = 11'($urandom_range(0, 1024));
			1: c.count = 11'd0;
			2: c.count = 11'd1024;
			default: c.count = 11'($urandom_range(1, 8));
		endcase
		c.red   = 8'($urandom);
		c.green = 8'($urandom);
		c.blue  = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 55)
			c.cmd = aled_pkg::CMD_TICK;
		else if (pick < 75)
			c.cmd = aled_pkg::CMD_SET;
		else if (pick < 90)
			c.cmd = aled_pkg::CMD_FILL;
		else
			c.cmd = aled_pkg::CMD_SHOW;
		return c;
	endfunction

	task automatic send_cmd(input led_cmd_t c);
		int unsigned gap;
		gap = rush ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.cmd;
		s_tdata  <= {2'b00, c.blue, c.green, c.red, c.count, c.first, c.strip};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [7:0] br, input logic [15:0] one,
			input logic [15:0] zero, input bit stray);
		write_reg(aled_pkg::CFG_BRIGHTNESS, {8'($urandom), br});
		write_reg(aled_pkg::CFG_DUTY_ONE, one);
		write_reg(aled_pkg::CFG_DUTY_ZERO, zero);
		if (stray)
			write_reg(CFG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_mix(input int unsigned n);
		repeat (n) send_cmd(random_pixel_cmd());
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= aled_pkg::CMD_TICK;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= aled_pkg::CFG_BRIGHTNESS;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(pixel_cmd(aled_pkg::CMD_TICK, 1, 1023, 1024, 8'hff, 8'hff, 8'hff));
		send_cmd(pixel_cmd(aled_pkg::CMD_SET, 0, 0, 0, 8'hff, 8'h01, 8'h80));
		send_cmd(pixel_cmd(aled_pkg::CMD_SET, 1, aled_pkg::LEDS_PER_STRIP - 1, 1,
			8'h00, 8'hff, 8'h00));
		send_cmd(pixel_cmd(aled_pkg::CMD_SET, 0, aled_pkg::LEDS_PER_STRIP, 0,
			8'hff, 8'hff, 8'hff));
		send_cmd(pixel_cmd(aled_pkg::CMD_SET, 1, 1023, 1024, 8'hff, 8'hff, 8'hff));
		send_cmd(pixel_cmd(aled_pkg::CMD_FILL, 0, 5, 0, 8'hff, 8'hff, 8'hff));
		send_cmd(pixel_cmd(aled_pkg::CMD_FILL, 1, 1023, 1024, 8'hff, 8'hff, 8'hff));
		send_cmd(pixel_cmd(aled_pkg::CMD_FILL, 0, aled_pkg::LEDS_PER_STRIP - 4, 1024,
			8'haa, 8'h55, 8'hff));
		send_cmd(pixel_cmd(aled_pkg::CMD_FILL, 1, 10, 3, 8'h12, 8'h34, 8'h56));

		// scaled snapshot, ticks at the reset duties
		settle();
		write_reg(aled_pkg::CFG_BRIGHTNESS, 16'd200);
		cfg_valid <= 1'b0;
		send_cmd(pixel_cmd(aled_pkg::CMD_SHOW, 0, 0, 0, 8'h00, 8'h00, 8'h00));
		send_cmd(pixel_cmd(aled_pkg::CMD_SHOW, 1, 1023, 1024, 8'hff, 8'hff, 8'hff));
		send_cmd(pixel_cmd(aled_pkg::CMD_SET, 0, 1, 0, 8'h11, 8'h22, 8'h33));
		send_cmd(pixel_cmd(aled_pkg::CMD_FILL, 1, 0, aled_pkg::LEDS_PER_STRIP,
			8'h44, 8'h55, 8'h66));
		repeat (400) send_cmd(pixel_cmd(aled_pkg::CMD_TICK, 0, 0, 0, 8'h00, 8'h00, 8'h00));

		// new duties and brightness while the frame is still being sent
		settle();
		configure(8'd0, 16'hffff, 16'h0000, 1'b1);
		run_mix(230);
		settle();

		configure(8'd255, 16'($urandom), 16'($urandom), 1'b0);
		rush = 1'b1;
		run_mix(115);
		rush = 1'b0;
		run_mix(115);
		settle();

		configure(8'd128, 16'h0000, 16'hffff, 1'b1);
		hold_off = 300;
		run_mix(230);
		settle();

		configure(8'd1, aled_pkg::DUTY_ONE_RST, aled_pkg::DUTY_ZERO_RST, 1'b1);
		rush = 1'b1;
		run_mix(50);
		rush = 1'b0;
		settle();

		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/aled_pkg.sv
hw/rtl/addressable_led_frame_encoder_unit.sv
sim/tb_top.sv
